### hw/rtl/bsc_pkg.sv
// Shared constants and beat payload types for the bubble sort core.
package bsc_pkg;

    // Default capacity of the element store
    localparam int MAX_ELEMENTS_DEF = 64;

    // Width of one element
    localparam int WORD_W = 32;

    // Width of the comparison and exchange counts
    localparam int COUNT_W = 11;

    // Input beat: one element, marked on the last one of a set
    typedef struct packed {
        logic signed [WORD_W-1:0] element;
        logic                     final_element;
    } in_item_t;

    // Output beat: one sorted element with the sort statistics
    typedef struct packed {
        logic signed [WORD_W-1:0] sorted_value;
        logic                     end_of_set;
        logic [COUNT_W-1:0]       comparisons;
        logic [COUNT_W-1:0]       exchanges;
        logic                     overflowed;
    } out_item_t;

endpackage

### hw/rtl/bsc_stream_if.sv
// Valid/ready stream channel carrying one payload per beat.
interface bsc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/bsc_store.sv
// Element store: one write port, one read port, registered read data.
module bsc_store #(
    parameter int DEPTH = bsc_pkg::MAX_ELEMENTS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [bsc_pkg::WORD_W-1:0]  wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [bsc_pkg::WORD_W-1:0]  rdata
);

    logic [bsc_pkg::WORD_W-1:0] mem_array [DEPTH];
    logic [bsc_pkg::WORD_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    // Read port; data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/bubble_sort_with_counts_core.sv
// Bubble sort core: loads a set, sorts it in place in memory, streams it out.
//
//  channel      dir  payload                                        beat taken when
//  in_stream    in   element, final_element                         valid && ready
//  out_stream   out  sorted_value, end_of_set, comparisons,         valid && ready
//                    exchanges, overflowed
//
// Loading writes each element into the store while it has room. The sort does
// one compare per cycle through the single read/write port pair of the store,
// plus a tail write and a restart read per pass. Output then streams one beat
// per cycle while out_stream is ready.
// in_stream is ready only while loading; out_stream may stall at any beat.
// Reset returns to loading with an empty set; the store itself is not cleared.
module bubble_sort_with_counts_core #(
    parameter int MAX_ELEMENTS = bsc_pkg::MAX_ELEMENTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    bsc_stream_if.sink    in_stream,
    bsc_stream_if.source  out_stream
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int WW = bsc_pkg::WORD_W;
    localparam int NW = bsc_pkg::COUNT_W;

    // Sequencer states
    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_RD0  = 3'd1;
    localparam logic [2:0] S_RD1  = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_TAIL = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]    state_reg,     state_next;
    logic [CW-1:0] count_reg,     count_next;
    logic          ovf_reg,       ovf_next;
    logic [NW-1:0] cmp_reg,       cmp_next;
    logic [NW-1:0] xch_reg,       xch_next;
    logic [AW-1:0] last_reg,      last_next;
    logic [AW-1:0] idx_reg,       idx_next;
    logic [CW-1:0] k_reg,         k_next;
    logic          a_valid_reg,   a_valid_next;
    logic          a_last_reg,    a_last_next;
    logic          out_valid_reg, out_valid_next;
    logic [WW-1:0] carry_reg,     carry_next;

    bsc_pkg::out_item_t out_item_reg, out_item_next;
    bsc_pkg::in_item_t  in_item;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [WW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [WW-1:0] mem_rdata;

    logic          store_full;
    logic [CW-1:0] n_final;
    logic [AW-1:0] idx_inc;
    logic          swap;
    logic          move;
    logic          issue;

    assign in_item = in_stream.payload;

    bsc_store #(
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Handshake outputs
    assign in_stream.ready    = (state_reg == S_LOAD);
    assign out_stream.valid   = out_valid_reg;
    assign out_stream.payload = out_item_reg;

    // Datapath helpers
    assign store_full = (count_reg == CW'(MAX_ELEMENTS));
    assign n_final    = store_full ? count_reg : (count_reg + CW'(1));
    assign idx_inc    = idx_reg + AW'(1);
    assign swap       = ($signed(carry_reg) > $signed(mem_rdata));
    assign move       = a_valid_reg && (!out_valid_reg || out_stream.ready);
    assign issue      = (state_reg == S_OUT) && (k_reg < count_reg)
                        && (!a_valid_reg || move);

    // Sequencer and memory port control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        cmp_next       = cmp_reg;
        xch_next       = xch_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        a_valid_next   = a_valid_reg;
        a_last_next    = a_last_reg;
        out_valid_next = out_valid_reg;
        carry_next     = carry_reg;
        out_item_next  = out_item_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_stream.valid)
                begin
                    if (!store_full)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[AW-1:0];
                        mem_wdata  = in_item.element;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_item.final_element)
                    begin
                        cmp_next = '0;
                        xch_next = '0;
                        k_next   = '0;
                        if (n_final >= CW'(2))
                        begin
                            last_next  = AW'(n_final - CW'(1));
                            state_next = S_RD0;
                        end
                        else
                        begin
                            state_next = S_OUT;
                        end
                    end
                end
            end

            S_RD0:
            begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = S_RD1;
            end

            // First element of the pass arrives; fetch the second
            S_RD1:
            begin
                carry_next = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = AW'(1);
                idx_next   = '0;
                state_next = S_CMP;
            end

            // Carry holds the running maximum of the pass
            S_CMP:
            begin
                cmp_next  = cmp_reg + NW'(1);
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                if (swap)
                begin
                    xch_next  = xch_reg + NW'(1);
                    mem_wdata = mem_rdata;
                end
                else
                begin
                    mem_wdata  = carry_reg;
                    carry_next = mem_rdata;
                end
                if (idx_inc == last_reg)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    idx_next  = idx_inc;
                    mem_re    = 1'b1;
                    mem_raddr = idx_inc + AW'(1);
                end
            end

            // Park the maximum at the end of the pass, restart at the front unless it was the last pass
            S_TAIL:
            begin
                mem_we    = 1'b1;
                mem_waddr = last_reg;
                mem_wdata = carry_reg;
                last_next = last_reg - AW'(1);
                if (last_reg == AW'(1))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = '0;
                    state_next = S_RD1;
                end
            end

            // Read data register acts as the stage ahead of the output register
            S_OUT:
            begin
                if (issue)
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = k_reg[AW-1:0];
                    k_next      = k_reg + CW'(1);
                    a_last_next = ((k_reg + CW'(1)) == count_reg);
                end
                if (issue)
                begin
                    a_valid_next = 1'b1;
                end
                else if (move)
                begin
                    a_valid_next = 1'b0;
                end
                if (out_valid_reg && out_stream.ready && out_item_reg.end_of_set)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = S_LOAD;
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        // Output register
        if (move)
        begin
            out_valid_next               = 1'b1;
            out_item_next.sorted_value   = mem_rdata;
            out_item_next.end_of_set     = a_last_reg;
            out_item_next.comparisons    = cmp_reg;
            out_item_next.exchanges      = xch_reg;
            out_item_next.overflowed     = ovf_reg;
        end
        else if (out_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            cmp_reg       <= '0;
            xch_reg       <= '0;
            last_reg      <= '0;
            idx_reg       <= '0;
            k_reg         <= '0;
            a_valid_reg   <= 1'b0;
            a_last_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            cmp_reg       <= cmp_next;
            xch_reg       <= xch_next;
            last_reg      <= last_next;
            idx_reg       <= idx_next;
            k_reg         <= k_next;
            a_valid_reg   <= a_valid_next;
            a_last_reg    <= a_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        carry_reg    <= carry_next;
        out_item_reg <= out_item_next;
    end

    // Checks
    a_no_output_while_loading: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> !out_valid_reg && !a_valid_reg
    ) else $error("output pipeline busy while loading");

    a_compare_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (idx_reg < last_reg)
    ) else $error("compare index beyond end of pass");

    a_no_same_entry_access: assert property (
        @(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr)
    ) else $error("read and write to the same store entry");

    a_exchanges_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.exchanges <= out_item_reg.comparisons)
    ) else $error("more exchanges than comparisons");

endmodule
